[design/smpd_pkg.sv]
// ----------------------------------------------------------------------------
// smpd_pkg: shared types and tables for the stepper phase driver
// Command record, register codes, sine table and duty scaling.
// ----------------------------------------------------------------------------
package smpd_pkg;

	localparam int MAX_MICRO_STEPS = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 7;
	localparam int DUTY_W          = 15;

	localparam logic [CFG_IDX_W-1:0] REG_MICRO_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY   = 2'd2;

	localparam logic FUNC_STEP  = 1'b0;
	localparam logic FUNC_SLEEP = 1'b1;

	localparam logic signed [DUTY_W-1:0] DUTY_POS = 15'sd10000;
	localparam logic signed [DUTY_W-1:0] DUTY_NEG = -15'sd10000;

	typedef struct packed {
		logic       step;   // 1 step, 0 hold
		logic       fwd;
		logic       micro;  // microstep mode
		logic [3:0] count;  // results this command gives, 1..8
		logic [2:0] inc;    // table increment per microstep
		logic [6:0] scale;  // duty scale in percent
	} cmd_t;

	// sine in percent, 32 entries per electrical cycle
	function automatic logic signed [7:0] sine_pct(input logic [4:0] idx);
		logic signed [7:0] v;
		unique case (idx[3:0])
			4'd0:  v = 8'sd0;
			4'd1:  v = 8'sd20;
			4'd2:  v = 8'sd38;
			4'd3:  v = 8'sd56;
			4'd4:  v = 8'sd71;
			4'd5:  v = 8'sd83;
			4'd6:  v = 8'sd92;
			4'd7:  v = 8'sd98;
			4'd8:  v = 8'sd100;
			4'd9:  v = 8'sd98;
			4'd10: v = 8'sd92;
			4'd11: v = 8'sd83;
			4'd12: v = 8'sd71;
			4'd13: v = 8'sd56;
			4'd14: v = 8'sd38;
			4'd15: v = 8'sd20;
			default: v = 8'sd0;
		endcase
		return idx[4] ? -v : v;
	endfunction

	// scale * table, saturated to +/-10000
	function automatic logic signed [DUTY_W-1:0] scaled_duty(input logic [6:0] scale,
		input logic [4:0] idx);
		logic signed [15:0] prod;
		logic signed [DUTY_W-1:0] res;
		prod = $signed({9'd0, scale}) * 16'(sine_pct(idx));
		if (prod > 16'sd10000) begin
			res = DUTY_POS;
		end else if (prod < -16'sd10000) begin
			res = DUTY_NEG;
		end else begin
			res = prod[DUTY_W-1:0];
		end
		return res;
	endfunction

	// table increment for a clamped microstep count of 2..8
	function automatic logic [2:0] micro_inc(input logic [3:0] n);
		logic [2:0] v;
		unique case (n)
			4'd2:    v = 3'd4;
			4'd3:    v = 3'd2;
			4'd4:    v = 3'd2;
			default: v = 3'd1;
		endcase
		return v;
	endfunction

endpackage

[design/stepper_microstep_phase_driver.sv]
// ----------------------------------------------------------------------------
// stepper_microstep_phase_driver: two-phase bipolar stepper duty generator
// Sine microstepping or two-phase-on full stepping with a hold command.
// ----------------------------------------------------------------------------
// Input side is a queue: an item (func, direction) is taken at an edge with
// push high and full low. A step in microstep mode gives micro_steps duty
// pairs (at most 8); a full step or a hold gives one. last marks the final
// pair of an item. Results are read like a queue: while empty is low the
// oldest pair is on duty_a/duty_b/last and leaves at an edge with pop high.
// Accepted items go into the command queue; the sequencer registers one pair
// per cycle into the result register while that is empty or being popped.
// A microstep item gives 2..8 pairs set by the microstep count, others one.
// A two-entry command queue sits between intake and sequencer, so items keep
// being taken while results wait. If the receiver stalls, the result register
// holds and the sequencer waits; full rises once the command queue has two
// items. The user must make config writes (cfg_we, cfg_idx, cfg_data) only
// while the block is idle; the block itself does not enforce it. Reset:
// micro_steps 1, max_duty 100, hold_duty 0, phase index 0, both queues empty.
// ----------------------------------------------------------------------------
module stepper_microstep_phase_driver import smpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     func,
	input  logic                     direction,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DUTY_W-1:0] duty_a,
	output logic signed [DUTY_W-1:0] duty_b,
	output logic                     last,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	cmd_t in_cmd;
	cmd_t head_cmd;
	logic q_empty;
	logic q_pop;

	smpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.func      (func),
		.direction (direction),
		.cmd       (in_cmd)
	);

	smpd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_cmd),
		.full   (full),
		.pop    (q_pop),
		.rdata  (head_cmd),
		.empty  (q_empty)
	);

	smpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.duty_a    (duty_a),
		.duty_b    (duty_b),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (duty_a <= DUTY_POS && duty_a >= DUTY_NEG &&
			duty_b <= DUTY_POS && duty_b >= DUTY_NEG))
		else $error("duty out of range");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !q_empty)
		else $error("accepted item missing from command queue");

	a_pop_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !empty && last)
		else $error("command retired without a final result");
`endif

endmodule

[design/smpd_front.sv]
// ----------------------------------------------------------------------------
// smpd_front: configuration registers and command classification
// Turns an accepted item into a command record for the back end.
// ----------------------------------------------------------------------------
module smpd_front import smpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  func,
	input  logic                  direction,
	output cmd_t                  cmd
);

	logic [3:0] micro_steps_q;
	logic [6:0] max_duty_q;
	logic [6:0] hold_duty_q;
	logic [3:0] n;
	logic       micro;
	logic       sleep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			micro_steps_q <= 4'd1;
			max_duty_q    <= 7'd100;
			hold_duty_q   <= 7'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MICRO_STEPS: micro_steps_q <= cfg_data[3:0];
				REG_MAX_DUTY:    max_duty_q    <= cfg_data;
				REG_HOLD_DUTY:   hold_duty_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		n     = (micro_steps_q > 4'(MAX_MICRO_STEPS)) ? 4'(MAX_MICRO_STEPS) : micro_steps_q;
		micro = n > 4'd1;
		sleep = func == FUNC_SLEEP;

		cmd.step  = !sleep;
		cmd.fwd   = direction;
		cmd.micro = micro;
		cmd.count = (sleep || !micro) ? 4'd1 : n;
		cmd.inc   = micro_inc(n);
		cmd.scale = (sleep && hold_duty_q < max_duty_q) ? hold_duty_q : max_duty_q;
	end

endmodule

[design/smpd_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// smpd_cmd_fifo: two-entry command queue
// Decouples item intake from result generation.
// ----------------------------------------------------------------------------
module smpd_cmd_fifo import smpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/smpd_back.sv]
// ----------------------------------------------------------------------------
// smpd_back: phase sequencer and result register
// Walks the phase index for the head command, one duty pair per cycle while the result register is empty or popped.
// ----------------------------------------------------------------------------
module smpd_back import smpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic                     cmd_empty,
	output logic                     cmd_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DUTY_W-1:0] duty_a,
	output logic signed [DUTY_W-1:0] duty_b,
	output logic                     last
);

	logic [4:0]              phase_q;
	logic [3:0]              k_q;
	logic                    out_valid_q;
	logic signed [DUTY_W-1:0] duty_a_q;
	logic signed [DUTY_W-1:0] duty_b_q;
	logic                    last_q;

	logic                    adv;
	logic                    is_last;
	logic [4:0]              next_idx;
	logic [1:0]              fp;
	logic signed [DUTY_W-1:0] da;
	logic signed [DUTY_W-1:0] db;

	assign adv     = !cmd_empty && (!out_valid_q || pop);
	assign is_last = (k_q + 4'd1) == cmd.count;
	assign cmd_pop = adv && is_last;

	always_comb begin
		next_idx = phase_q;
		if (cmd.step) begin
			if (cmd.micro) begin
				next_idx = cmd.fwd ? phase_q + {2'b00, cmd.inc} : phase_q - {2'b00, cmd.inc};
			end else begin
				next_idx = {3'b000, cmd.fwd ? phase_q[1:0] + 2'd1 : phase_q[1:0] - 2'd1};
			end
		end
		fp = next_idx[1:0];
		if (cmd.micro) begin
			da = scaled_duty(cmd.scale, next_idx);
			db = scaled_duty(cmd.scale, next_idx + 5'd8);
		end else begin
			// two-phase-on: a leads b by one full step
			da = fp[1] ? DUTY_NEG : DUTY_POS;
			db = (fp[1] ^ fp[0]) ? DUTY_POS : DUTY_NEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 5'd0;
			k_q         <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q     <= next_idx;
				k_q         <= is_last ? 4'd0 : k_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty_a_q <= da;
			duty_b_q <= db;
			last_q   <= is_last;
		end
	end

	assign empty  = !out_valid_q;
	assign duty_a = duty_a_q;
	assign duty_b = duty_b_q;
	assign last   = last_q;

endmodule
